/* hw/rtl/sba_pkg.sv */
`timescale 1ns / 1ps

package sba_pkg;

    // Default disk geometry
    localparam int SBA_TRACKS           = 40;
    localparam int SBA_SECTORS_PER_TRACK = 16;
    localparam int SBA_BYTES_PER_SECTOR = 126;

    typedef enum logic [2:0] {
        FN_MARK  = 3'd0,
        FN_FREE  = 3'd1,
        FN_QUERY = 3'd2,
        FN_FIND  = 3'd3,
        FN_LOAD  = 3'd4,
        FN_READ  = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EXEC,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0] func;
        logic [5:0] track_no;
        logic [3:0] sector_no;
        logic [6:0] map_index;
        logic [7:0] map_data;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic        in_use;
        logic [5:0]  found_track;
        logic [3:0]  found_sector;
        logic [7:0]  map_out;
        logic [16:0] free_bytes;
    } t_rsp;

    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] c;
        c = 4'd0;
        for (int i = 0; i < 8; i++) begin
            c = c + 4'(v[i]);
        end
        return c;
    endfunction

endpackage

/* hw/rtl/sector_bitmap_allocator.sv */
`timescale 1ns / 1ps

// Sector usage bitmap for tracks 1..TRACKS-1 of a disk.
// Request channel (i_req_valid / o_req_ready, payload i_req): mark a sector
// used, mark it free, query it, find the lowest free sector, load one raw
// map byte or read one back. Response channel (o_rsp_valid / i_rsp_ready,
// payload o_rsp): exactly one response per request, in order, always
// carrying the free space (free sectors * BYTES_PER_SECTOR) after the
// request.
// Mark/free/query/load/read pass through the read, execute and completion
// states; a bad address, index or function skips the execute state. Find
// scans the map one byte per cycle through the single memory read port,
// stopping at the first byte with a free sector or at the end of the map.
// One request is in flight at a time; o_req_ready is high only while the
// sequencer is idle, so the next request is not taken until the last one
// has loaded its response register.
// Response is held in an output register: a stalled receiver delays only
// the final hand-off, and the next request is taken as soon as the response
// register has been loaded.
// Reset (synchronous, active low) clears the per-byte valid bits, so the
// whole map reads as free at once, and clears the used-sector count.
module sector_bitmap_allocator
    import sba_pkg::*;
#(
    parameter int TRACKS            = SBA_TRACKS,
    parameter int SECTORS_PER_TRACK = SBA_SECTORS_PER_TRACK,
    parameter int BYTES_PER_SECTOR  = SBA_BYTES_PER_SECTOR
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    localparam int MAP_BITS  = (TRACKS - 1) * SECTORS_PER_TRACK;
    localparam int MAP_BYTES = (MAP_BITS + 7) / 8;
    localparam int AW  = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int BW  = $clog2(MAP_BITS);
    localparam int UW  = $clog2(MAP_BITS + 1);
    localparam int TW  = $clog2(TRACKS);
    localparam int SW  = $clog2(SECTORS_PER_TRACK + 8);
    localparam int PW  = UW + $clog2(BYTES_PER_SECTOR + 1);
    localparam int LAST_BITS = MAP_BITS - (MAP_BYTES - 1) * 8;
    localparam logic [8:0] LAST_MASK9 = (9'd1 << LAST_BITS) - 9'd1;
    localparam logic [7:0] LAST_MASK  = LAST_MASK9[7:0];
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_BYTES - 1);

    // Map storage; valid bits stand in for a clearing pass
    logic [7:0]           r_map [MAP_BYTES];
    logic [MAP_BYTES-1:0] r_vld;
    logic [7:0]           r_rdata;
    logic                 r_rvld;
    logic [AW-1:0]        r_daddr;

    t_state        r_state, n_state;
    logic [2:0]    r_func, n_func;
    logic          r_bad, n_bad;
    logic [AW-1:0] r_addr, n_addr;
    logic [2:0]    r_bpos, n_bpos;
    logic [7:0]    r_data, n_data;
    logic [UW-1:0] r_used, n_used;
    logic [TW-1:0] r_btrk, n_btrk;   // track/sector of bit 0 of byte r_daddr
    logic [SW-1:0] r_bsec, n_bsec;
    logic [1:0]    r_status, n_status;
    logic          r_in_use, n_in_use;
    logic [TW-1:0] r_ft, n_ft;
    logic [SW-1:0] r_fs, n_fs;
    logic [7:0]    r_mo, n_mo;
    t_rsp          r_rsp, n_rsp;
    logic          r_rsp_valid, n_rsp_valid;

    logic          w_we;
    logic [7:0]    w_wdata;

    // Request decode
    logic          w_addr_ok;
    logic          w_idx_bad;
    logic [BW-1:0] w_bit_idx;
    logic [AW-1:0] w_byte;

    // Execute / scan datapath
    logic [7:0]    w_eff;
    logic [7:0]    w_mask;
    logic          w_was;
    logic [7:0]    w_onehot;
    logic [7:0]    w_nv;
    logic [7:0]    w_free;
    logic [2:0]    w_pos;
    logic [SW-1:0] w_sum;
    logic [SW-1:0] w_adv;
    logic [UW-1:0] w_free_sec;
    logic [PW-1:0] w_prod;

    assign w_addr_ok = (i_req.track_no != 6'd0)
                    && (32'(i_req.track_no) < TRACKS)
                    && (32'(i_req.sector_no) < SECTORS_PER_TRACK);
    assign w_idx_bad = (32'(i_req.map_index) >= MAP_BYTES);
    assign w_bit_idx = BW'((BW'(i_req.track_no) - BW'(1)) * BW'(SECTORS_PER_TRACK)
                     + BW'(i_req.sector_no));
    assign w_byte    = AW'(w_bit_idx >> 3);

    assign w_eff    = r_rvld ? r_rdata : 8'h00;
    assign w_mask   = (r_daddr == LAST_ADDR) ? LAST_MASK : 8'hFF;
    assign w_was    = w_eff[r_bpos];
    assign w_onehot = 8'h01 << r_bpos;
    assign w_nv     = r_data & w_mask;
    assign w_free   = ~w_eff & w_mask;

    always_comb begin
        w_pos = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (w_free[i]) begin
                w_pos = 3'(i);
            end
        end
    end

    assign w_sum = r_bsec + SW'(w_pos);
    assign w_adv = r_bsec + SW'(8);

    // Free space, from the count already updated by the request
    assign w_free_sec = UW'(MAP_BITS) - r_used;
    assign w_prod     = PW'(w_free_sec) * PW'(BYTES_PER_SECTOR);

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_bad       = r_bad;
        n_addr      = r_addr;
        n_bpos      = r_bpos;
        n_data      = r_data;
        n_used      = r_used;
        n_btrk      = r_btrk;
        n_bsec      = r_bsec;
        n_status    = r_status;
        n_in_use    = r_in_use;
        n_ft        = r_ft;
        n_fs        = r_fs;
        n_mo        = r_mo;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        w_we        = 1'b0;
        w_wdata     = w_eff;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_func   = i_req.func;
                    n_data   = i_req.map_data;
                    n_bpos   = w_bit_idx[2:0];
                    n_status = ST_OK;
                    n_in_use = 1'b0;
                    n_ft     = '0;
                    n_fs     = '0;
                    n_mo     = 8'h00;
                    n_btrk   = TW'(1);
                    n_bsec   = '0;
                    n_state  = S_RD;
                    unique case (i_req.func)
                        FN_MARK, FN_FREE, FN_QUERY: begin
                            n_bad  = !w_addr_ok;
                            n_addr = w_addr_ok ? w_byte : '0;
                        end
                        FN_FIND: begin
                            n_bad  = 1'b0;
                            n_addr = '0;
                        end
                        FN_LOAD, FN_READ: begin
                            n_bad  = w_idx_bad;
                            n_addr = w_idx_bad ? '0 : AW'(i_req.map_index);
                        end
                        default: begin
                            n_bad  = 1'b1;
                            n_addr = '0;
                        end
                    endcase
                end
            end
            S_RD: begin
                // memory read of r_addr lands at the end of this cycle
                if (r_bad) begin
                    n_status = ST_INVALID;
                    n_state  = S_DONE;
                end else if (r_func == FN_FIND) begin
                    n_addr  = (r_addr == LAST_ADDR) ? r_addr : r_addr + AW'(1);
                    n_state = S_SCAN;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_func)
                    FN_MARK: begin
                        if (!w_was) begin
                            w_we    = 1'b1;
                            w_wdata = w_eff | w_onehot;
                            n_used  = r_used + UW'(1);
                        end
                    end
                    FN_FREE: begin
                        if (w_was) begin
                            w_we    = 1'b1;
                            w_wdata = w_eff & ~w_onehot;
                            n_used  = r_used - UW'(1);
                        end
                    end
                    FN_QUERY: begin
                        n_in_use = w_was;
                    end
                    FN_LOAD: begin
                        w_we    = 1'b1;
                        w_wdata = w_nv;
                        n_used  = r_used - UW'(pop8(w_eff)) + UW'(pop8(w_nv));
                    end
                    FN_READ: begin
                        n_mo = w_eff;
                    end
                    default: begin
                        n_status = ST_INVALID;
                    end
                endcase
                n_state = S_DONE;
            end
            S_SCAN: begin
                if (|w_free) begin
                    if (32'(w_sum) >= SECTORS_PER_TRACK) begin
                        n_fs = w_sum - SW'(SECTORS_PER_TRACK);
                        n_ft = r_btrk + TW'(1);
                    end else begin
                        n_fs = w_sum;
                        n_ft = r_btrk;
                    end
                    n_state = S_DONE;
                end else if (r_daddr == LAST_ADDR) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    // step the base position by one byte (at most one wrap)
                    if (32'(w_adv) >= SECTORS_PER_TRACK) begin
                        n_bsec = w_adv - SW'(SECTORS_PER_TRACK);
                        n_btrk = r_btrk + TW'(1);
                    end else begin
                        n_bsec = w_adv;
                    end
                    n_addr = (r_addr == LAST_ADDR) ? r_addr : r_addr + AW'(1);
                end
            end
            S_DONE: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    n_rsp.status       = r_status;
                    n_rsp.in_use       = r_in_use;
                    n_rsp.found_track  = 6'(r_ft);
                    n_rsp.found_sector = 4'(r_fs);
                    n_rsp.map_out      = r_mo;
                    n_rsp.free_bytes   = 17'(w_prod);
                    n_rsp_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_rsp_valid <= 1'b0;
            r_vld       <= '0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_rsp_valid <= n_rsp_valid;
            if (w_we) begin
                r_vld[r_daddr] <= 1'b1;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_bad    <= n_bad;
        r_addr   <= n_addr;
        r_bpos   <= n_bpos;
        r_data   <= n_data;
        r_btrk   <= n_btrk;
        r_bsec   <= n_bsec;
        r_status <= n_status;
        r_in_use <= n_in_use;
        r_ft     <= n_ft;
        r_fs     <= n_fs;
        r_mo     <= n_mo;
        r_rsp    <= n_rsp;
    end

    // Map memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_map[r_daddr] <= w_wdata;
        end
        r_rdata <= r_map[r_addr];
        r_rvld  <= r_vld[r_addr];
        r_daddr <= r_addr;
    end

    // Count of used sectors can never pass the map size
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(MAP_BITS))
        else $error("used sector count out of range");

    // A taken request closes the request channel on the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_req_ready)
        else $error("second request taken while busy");

    // Response appears only out of the completion state
    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(r_state == S_DONE))
        else $error("response raised outside completion");

    // Scan never looks past the end of the map
    a_scan_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (32'(r_daddr) < MAP_BYTES))
        else $error("scan address beyond map");

    // Found sector stays inside its track
    a_found_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (32'(r_fs) < SECTORS_PER_TRACK))
        else $error("found sector out of range");

endmodule
